>>> hw/rtl/mbe_pkg.sv
// shared constants, register indexes and multiplier handshake types for the escape-time block
package mbe_pkg;

  // fixed point format of coordinates and z
  localparam int FRAC_BITS = 52;
  // width of the pixel coordinates
  localparam int COORD_BITS = 11;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_REAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IMAG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT  = 3'd4;

  // signed width of corner plus coordinate times step
  localparam int C_W = 63 + COORD_BITS + 2;
  // signed width of a product term plus c
  localparam int Z_W = 131 - FRAC_BITS;
  // shift from the 2*FRAC_BITS square format down to Q24.40
  localparam int MAG_SHIFT = 2 * FRAC_BITS - 40;

  // request to the shared 64x64 multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // response of the shared 64x64 multiplier
  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;

endpackage

>>> hw/rtl/mandelbrot_escape_time.sv
// escape-time iteration for one pixel: c from the pixel position, then z = z*z + c
//
// Usage: the input channel (in_valid/in_ready) takes one word per pixel, a column and a
// row. The block forms c from the configured corner and pixel step, iterates from z = 0
// and returns one word on the output channel (out_valid/out_ready): escaped flag,
// iteration count and final |z|^2 in unsigned Q24.40, saturating.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while no pixel is in
// flight; indexes above the register list are ignored.
// Timing: one pixel is worked on at a time. Forming c takes two 64x64 products, and each
// iteration a check state, three products, two add states and the escape test. A pixel
// that escapes loads its result word sooner than one that runs to the cap; the next
// pixel is accepted in the cycle after the load at the earliest.
// The pace is set by the single shared 32x32 multiplier, which builds three 64x64
// products per iteration (z_real*z_imag and the two squares) from four partial products
// each.
// The result sits in an output register: the next pixel is accepted while a finished
// word waits, and a stalled receiver only holds the block once the next result is due.
// Reset (synchronous, active low) returns to idle with no result pending and loads the
// register defaults: corner and step zero, cap 1000, limit 2^20.
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pixel_column,
  input  logic [COORD_BITS-1:0] in_pixel_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_escaped,
  output logic [19:0]           out_iteration_count,
  output logic [63:0]           out_final_magnitude_sq,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]           cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_C_RE  = 4'd1;
  localparam logic [3:0] S_C_IM  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_PROD  = 4'd4;
  localparam logic [3:0] S_TERM  = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_SQR_R = 4'd7;
  localparam logic [3:0] S_SQR_I = 4'd8;
  localparam logic [3:0] S_TEST  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]            state_r;
  logic [3:0]            state_nxt;

  // configuration registers
  logic [63:0]           left_real_r;
  logic [63:0]           top_imag_r;
  logic [62:0]           pixel_step_r;
  logic [19:0]           max_iter_r;
  logic [20:0]           esc_limit_r;

  // per-pixel working registers
  logic [COORD_BITS-1:0] row_r;
  logic [63:0]           c_re_r;
  logic [63:0]           c_im_r;
  logic [63:0]           z_re_r;
  logic [63:0]           z_im_r;
  logic [127:0]          a2_r;
  logic [127:0]          b2_r;
  logic [Z_W-1:0]        prod_term_r;
  logic [127:0]          dmag_r;
  logic                  dneg_r;
  logic [Z_W-1:0]        re_term_r;
  logic [Z_W-1:0]        im_sum_r;
  logic [19:0]           iter_cnt_r;
  logic                  esc_r;
  logic [63:0]           mag_r;

  // output register
  logic                  out_valid_r;
  logic                  out_escaped_r;
  logic [19:0]           out_count_r;
  logic [63:0]           out_mag_r;
  logic                  out_load;

  mul_req_t              mul_req;
  mul_rsp_t              mul_rsp;

  // datapath
  logic [C_W-1:0]        c_re_sum;
  logic [C_W-1:0]        c_im_sum;
  logic [63:0]           c_re_sat;
  logic [63:0]           c_im_sat;
  logic [63:0]           zr_mag;
  logic [63:0]           zi_mag;
  logic [127:0]          pshift;
  logic [Z_W-1:0]        pmag;
  logic [Z_W-1:0]        dshift;
  logic [Z_W-1:0]        re_sum;
  logic                  re_fit;
  logic                  im_fit;
  logic [63:0]           re_new_mag;
  logic [127:0]          sq_sum;
  logic [127:0]          limit;
  logic [127:0]          q_shift;
  logic [63:0]           mag_val;
  logic                  over;

  mbe_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // c = corner +/- coordinate * step, saturated to 64 bits
  always_comb begin
    c_re_sum = {{(C_W-64){left_real_r[63]}}, left_real_r}
             + C_W'(mul_rsp.p[62+COORD_BITS:0]);
    c_im_sum = {{(C_W-64){top_imag_r[63]}}, top_imag_r}
             - C_W'(mul_rsp.p[62+COORD_BITS:0]);
    if ((&c_re_sum[C_W-1:63]) || !(|c_re_sum[C_W-1:63])) begin
      c_re_sat = c_re_sum[63:0];
    end else begin
      c_re_sat = c_re_sum[C_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    if ((&c_im_sum[C_W-1:63]) || !(|c_im_sum[C_W-1:63])) begin
      c_im_sat = c_im_sum[63:0];
    end else begin
      c_im_sat = c_im_sum[C_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
  end

  // magnitudes, product terms and the new z
  always_comb begin
    zr_mag     = z_re_r[63] ? 64'd0 - z_re_r : z_re_r;
    zi_mag     = z_im_r[63] ? 64'd0 - z_im_r : z_im_r;
    pshift     = mul_rsp.p >> (FRAC_BITS - 1);
    pmag       = Z_W'(pshift[128-FRAC_BITS:0]);
    dshift     = Z_W'(dmag_r[127:FRAC_BITS]);
    re_sum     = re_term_r + {{(Z_W-64){c_re_r[63]}}, c_re_r};
    re_fit     = (&re_sum[Z_W-1:63]) || !(|re_sum[Z_W-1:63]);
    im_fit     = (&im_sum_r[Z_W-1:63]) || !(|im_sum_r[Z_W-1:63]);
    re_new_mag = re_sum[63] ? 64'd0 - re_sum[63:0] : re_sum[63:0];
  end

  // escape test and Q24.40 magnitude
  always_comb begin
    sq_sum  = a2_r + b2_r;
    limit   = 128'(esc_limit_r) << (2 * FRAC_BITS);
    over    = sq_sum > limit;
    q_shift = sq_sum >> MAG_SHIFT;
    mag_val = (|q_shift[127:64]) ? {64{1'b1}} : q_shift[63:0];
  end

  // sequencer and multiplier requests
  always_comb begin
    state_nxt     = state_r;
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt     = S_C_RE;
          mul_req.start = 1'b1;
          mul_req.a     = 64'(in_pixel_column);
          mul_req.b     = {1'b0, pixel_step_r};
        end
      end
      S_C_RE: begin
        if (mul_rsp.done) begin
          state_nxt     = S_C_IM;
          mul_req.start = 1'b1;
          mul_req.a     = 64'(row_r);
          mul_req.b     = {1'b0, pixel_step_r};
        end
      end
      S_C_IM: begin
        if (mul_rsp.done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (iter_cnt_r == max_iter_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt     = S_PROD;
          mul_req.start = 1'b1;
          mul_req.a     = zr_mag;
          mul_req.b     = zi_mag;
        end
      end
      S_PROD: begin
        if (mul_rsp.done) begin
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (!re_fit || !im_fit) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt     = S_SQR_R;
          mul_req.start = 1'b1;
          mul_req.a     = re_new_mag;
          mul_req.b     = re_new_mag;
        end
      end
      S_SQR_R: begin
        if (mul_rsp.done) begin
          state_nxt     = S_SQR_I;
          mul_req.start = 1'b1;
          mul_req.a     = zi_mag;
          mul_req.b     = zi_mag;
        end
      end
      S_SQR_I: begin
        if (mul_rsp.done) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        state_nxt = over ? S_FIN : S_CHECK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_real_r  <= 64'd0;
      top_imag_r   <= 64'd0;
      pixel_step_r <= 63'd0;
      max_iter_r   <= 20'd1000;
      esc_limit_r  <= 21'd1048576;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEFT_REAL:  left_real_r  <= cfg_data;
        REG_TOP_IMAG:   top_imag_r   <= cfg_data;
        REG_PIXEL_STEP: pixel_step_r <= cfg_data[62:0];
        REG_MAX_ITER:   max_iter_r   <= cfg_data[19:0];
        REG_ESC_LIMIT:  esc_limit_r  <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // per-pixel datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          row_r <= in_pixel_row;
        end
      end
      S_C_RE: begin
        if (mul_rsp.done) begin
          c_re_r <= c_re_sat;
        end
      end
      S_C_IM: begin
        if (mul_rsp.done) begin
          c_im_r     <= c_im_sat;
          z_re_r     <= 64'd0;
          z_im_r     <= 64'd0;
          a2_r       <= '0;
          b2_r       <= '0;
          iter_cnt_r <= 20'd0;
          esc_r      <= 1'b0;
          mag_r      <= 64'd0;
        end
      end
      S_PROD: begin
        if (mul_rsp.done) begin
          // 2*|zr|*|zi| truncated toward zero, then signed
          prod_term_r <= (z_re_r[63] ^ z_im_r[63]) ? Z_W'(0) - pmag : pmag;
          dneg_r      <= a2_r < b2_r;
          dmag_r      <= (a2_r < b2_r) ? b2_r - a2_r : a2_r - b2_r;
        end
      end
      S_TERM: begin
        im_sum_r  <= prod_term_r + {{(Z_W-64){c_im_r[63]}}, c_im_r};
        re_term_r <= dneg_r ? Z_W'(0) - dshift : dshift;
      end
      S_ADD: begin
        iter_cnt_r <= iter_cnt_r + 20'd1;
        if (re_fit && im_fit) begin
          z_re_r <= re_sum[63:0];
          z_im_r <= im_sum_r[63:0];
        end else begin
          // overflow of z counts as an escape
          esc_r <= 1'b1;
          mag_r <= {64{1'b1}};
        end
      end
      S_SQR_R: begin
        if (mul_rsp.done) begin
          a2_r <= mul_rsp.p;
        end
      end
      S_SQR_I: begin
        if (mul_rsp.done) begin
          b2_r <= mul_rsp.p;
        end
      end
      S_TEST: begin
        mag_r <= mag_val;
        if (over) begin
          esc_r <= 1'b1;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_escaped_r <= esc_r;
          out_count_r   <= iter_cnt_r;
          out_mag_r     <= mag_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_escaped            = out_escaped_r;
  assign out_iteration_count    = out_count_r;
  assign out_final_magnitude_sq = out_mag_r;

endmodule

>>> hw/rtl/mbe_mul64.sv
// 64x64 unsigned multiplier built from four 32x32 partial products, computed in turn and accumulated
module mbe_mul64 import mbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic         pv_r;
  logic         done_r;
  logic [1:0]   pidx_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp_nxt;
  logic [127:0] pp_shifted;

  // operand halves for the current partial product
  always_comb begin
    a_half = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    b_half = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp_nxt = 64'(a_half) * 64'(b_half);
  end

  // align the registered partial product
  always_comb begin
    case (pidx_r)
      2'd0:    pp_shifted = {64'b0, pp_r};
      2'd3:    pp_shifted = {pp_r, 64'b0};
      default: pp_shifted = {32'b0, pp_r, 32'b0};
    endcase
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        pv_r <= (cnt_r != 3'd4);
        if (cnt_r != 3'd4) begin
          cnt_r <= cnt_r + 3'd1;
        end
        if (pv_r && pidx_r == 2'd3) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  // operands, partial products and accumulation
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        pp_r   <= pp_nxt;
        pidx_r <= cnt_r[1:0];
      end
      if (pv_r) begin
        acc_r <= acc_r + pp_shifted;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

>>> tb/mandelbrot_escape_time_tb.sv
// testbench for mandelbrot_escape_time: pixel views checked against an escape-time predictor
module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int RANDOM_VIEWS = 12;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC_BITS;

  typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } pixel_pos_t;

  typedef struct packed {
    logic        escaped;
    logic [19:0] count;
    logic [63:0] mag_sq;
  } escape_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] in_pixel_column = '0;
  logic [COORD_BITS-1:0] in_pixel_row = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_escaped;
  logic [19:0]           out_iteration_count;
  logic [63:0]           out_final_magnitude_sq;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [63:0]           cfg_data = '0;

  // copy of the register file, reset defaults
  logic signed [63:0] corner_re = '0;
  logic signed [63:0] corner_im = '0;
  logic [62:0]        pixel_step = '0;
  logic [19:0]        iter_cap = 20'd1000;
  logic [20:0]        escape_bound = 21'd1048576;

  pixel_pos_t     pixels_to_send[$];
  escape_result_t results_due[$];
  int unsigned    pixels_pushed = 0;
  int unsigned    pixels_accepted = 0;
  int unsigned    mismatches = 0;
  int unsigned    quiet_cycles = 0;
  pace_t          pace = PACE_SLOW_SINK;

  mandelbrot_escape_time u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_pixel_column        (in_pixel_column),
    .in_pixel_row           (in_pixel_row),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_escaped            (out_escaped),
    .out_iteration_count    (out_iteration_count),
    .out_final_magnitude_sq (out_final_magnitude_sq),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit idle_roll(input int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic bit fits_q64(input logic signed [131:0] v);
    return v >= 132'(S64_MIN) && v <= 132'(S64_MAX);
  endfunction

  function automatic logic signed [131:0] clamp_q64(input logic signed [131:0] v);
    if (v > 132'(S64_MAX)) return 132'(S64_MAX);
    if (v < 132'(S64_MIN)) return 132'(S64_MIN);
    return v;
  endfunction

  // z = z*z + c from zero, products exact, terms truncated toward zero
  function automatic escape_result_t escape_time(input logic [COORD_BITS-1:0] col,
                                                 input logic [COORD_BITS-1:0] row);
    logic signed [131:0] lr, ti, off_re, off_im, c_re, c_im;
    logic signed [131:0] zr, zi, ar, ai, a2, b2, prod, diff, nre, nim, mag_sum, bound;
    escape_result_t r;
    int unsigned n;
    lr = 132'(corner_re);
    ti = 132'(corner_im);
    off_re = 132'(col) * 132'(pixel_step);
    off_im = 132'(row) * 132'(pixel_step);
    c_re = clamp_q64(lr + off_re);
    c_im = clamp_q64(ti - off_im);
    bound = 132'(escape_bound);
    bound = bound <<< (2 * FRAC_BITS);
    zr = '0;
    zi = '0;
    n = 0;
    r = '0;
    while (n < 32'(iter_cap)) begin
      ar = (zr < 0) ? -zr : zr;
      ai = (zi < 0) ? -zi : zi;
      a2 = ar * ar;
      b2 = ai * ai;
      prod = (ar * ai) >> (FRAC_BITS - 1);
      if ((zr < 0) != (zi < 0)) prod = -prod;
      nim = prod + c_im;
      if (a2 >= b2) diff = (a2 - b2) >> FRAC_BITS;
      else diff = -((b2 - a2) >> FRAC_BITS);
      nre = diff + c_re;
      n++;
      // z leaving the signed 64-bit range is an escape with saturated magnitude
      if (!fits_q64(nre) || !fits_q64(nim)) begin
        r.escaped = 1'b1;
        r.mag_sq = '1;
        break;
      end
      zr = nre;
      zi = nim;
      mag_sum = zr * zr + zi * zi;
      if (mag_sum[131:MAG_SHIFT+64] != '0) r.mag_sq = '1;
      else r.mag_sq = 64'(mag_sum >> MAG_SHIFT);
      if (mag_sum > bound) begin
        r.escaped = 1'b1;
        break;
      end
    end
    r.count = n[19:0];
    return r;
  endfunction

  // one register write, mirrored into the local copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_LEFT_REAL:  corner_re = data;
      REG_TOP_IMAG:   corner_im = data;
      REG_PIXEL_STEP: pixel_step = data[62:0];
      REG_MAX_ITER:   iter_cap = data[19:0];
      REG_ESC_LIMIT:  escape_bound = data[20:0];
      default: ;
    endcase
  endtask

  task automatic load_view(input logic [63:0] left, input logic [63:0] top,
                           input logic [63:0] step_w, input logic [63:0] cap_w,
                           input logic [63:0] bound_w, input bit poke_unused);
    write_reg(REG_LEFT_REAL, left);
    write_reg(REG_TOP_IMAG, top);
    write_reg(REG_PIXEL_STEP, step_w);
    write_reg(REG_MAX_ITER, cap_w);
    write_reg(REG_ESC_LIMIT, bound_w);
    // indexes past the register list must leave everything alone
    if (poke_unused)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_ESC_LIMIT) + 1, (1 << CFG_IDX_W) - 1)),
                rand64());
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_pixel(input int unsigned col, input int unsigned row);
    pixel_pos_t p;
    p.col = col[COORD_BITS-1:0];
    p.row = row[COORD_BITS-1:0];
    pixels_to_send.push_back(p);
    pixels_pushed++;
  endtask

  // hold the sender back until every result has come home
  task automatic drain();
    while (pixels_accepted != pixels_pushed || results_due.size() != 0) @(posedge clk);
  endtask

  // input driver and prediction at acceptance
  always @(posedge clk) begin
    pixel_pos_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pixels_accepted++;
        results_due.push_back(escape_time(in_pixel_column, in_pixel_row));
      end
      if (!in_valid || in_ready) begin
        if (pixels_to_send.size() != 0 &&
            !idle_roll(pace == PACE_SLOW_SOURCE ? 83 : pace == PACE_SLOW_SINK ? 25 : 0)) begin
          nxt = pixels_to_send.pop_front();
          in_valid <= 1'b1;
          in_pixel_column <= nxt.col;
          in_pixel_row <= nxt.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_roll(pace == PACE_SLOW_SINK ? 83 : pace == PACE_SLOW_SOURCE ? 25 : 0);
    end
  end

  // result monitor
  always @(posedge clk) begin
    escape_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word with no pixel pending: escaped %0d count %0d mag %h",
                 $time, out_escaped, out_iteration_count, out_final_magnitude_sq);
      end else begin
        want = results_due.pop_front();
        if (out_escaped !== want.escaped) begin
          mismatches++;
          $display("%0t: escaped expected %0d, got %0d", $time, want.escaped, out_escaped);
        end
        if (out_iteration_count !== want.count) begin
          mismatches++;
          $display("%0t: iteration_count expected %0d, got %0d",
                   $time, want.count, out_iteration_count);
        end
        if (out_final_magnitude_sq !== want.mag_sq) begin
          mismatches++;
          $display("%0t: final_magnitude_sq expected %h, got %h",
                   $time, want.mag_sq, out_final_magnitude_sq);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus: directed views first, then random views
  initial begin
    int unsigned kind, sel, n_items;
    logic signed [63:0] left, top;
    logic [62:0] step;
    logic [19:0] cap;
    logic [20:0] bnd;
    logic [63:0] noise;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: c is zero, runs to the 1000 cap
    push_pixel(0, 0);
    drain();

    // classic view, corners of the pixel range, points inside and outside the set
    load_view(-(Q_ONE <<< 1), Q_ONE, 64'd1 << 42, 64'd32, 64'd4, 1'b0);
    push_pixel(0, 0);
    push_pixel(COORD_MAX, COORD_MAX);
    push_pixel(COORD_MAX, 0);
    push_pixel(0, COORD_MAX);
    push_pixel(1024, 1024);
    push_pixel(1536, 1024);
    push_pixel(1700, 700);
    drain();

    // zero cap
    load_view(-(Q_ONE <<< 1), Q_ONE, 64'd1 << 42, 64'd0, 64'd4, 1'b0);
    push_pixel(3, 4);
    push_pixel(COORD_MAX, COORD_MAX);
    drain();

    // zero limit, c of one lsb
    load_view(64'd0, 64'd0, 64'd1, 64'd10, 64'd0, 1'b0);
    push_pixel(0, 0);
    push_pixel(1, 0);
    push_pixel(0, 1);
    drain();

    // c saturates, all-ones writes masked to register widths, largest cap and limit
    load_view(S64_MAX, S64_MIN, '1, '1, '1, 1'b0);
    push_pixel(COORD_MAX, COORD_MAX);
    push_pixel(0, 0);
    push_pixel(COORD_MAX, 0);
    push_pixel(0, COORD_MAX);
    drain();

    // z overflow on the second iteration, limit met exactly, unused index poked
    load_view(Q_ONE * 1000, 64'd0, Q_ONE, 64'd10, 64'd1 << 20, 1'b1);
    push_pixel(0, 0);
    push_pixel(24, 0);
    push_pixel(0, 1000);
    push_pixel(COORD_MAX, 0);
    drain();

    for (int p = 0; p < RANDOM_VIEWS; p++) begin
      pace = (p < RANDOM_VIEWS / 3) ? PACE_SLOW_SINK :
             (p < 2 * RANDOM_VIEWS / 3) ? PACE_SLOW_SOURCE : PACE_FULL;
      kind = $urandom_range(99, 0);
      if (kind < 60) begin
        // view around the set at a random zoom
        left = $signed(rand64() >> 11) - (Q_ONE <<< 1);
        top = $signed(rand64() >> 11) - (Q_ONE >>> 1);
        step = 63'(rand64() >> $urandom_range(36, 21));
      end else if (kind < 80) begin
        // raw register values, c mostly far out or saturated
        left = rand64();
        top = rand64();
        step = 63'(rand64());
      end else begin
        // corner anywhere in range, fine steps, reaches z overflow
        left = $signed(rand64()) >>> $urandom_range(10, 0);
        top = $signed(rand64()) >>> $urandom_range(10, 0);
        step = 63'(rand64() >> $urandom_range(63, 12));
      end
      sel = $urandom_range(15, 0);
      if (sel == 0) cap = '0;
      else if (sel < 4) cap = 20'($urandom_range(160, 65));
      else cap = 20'($urandom_range(48, 1));
      sel = $urandom_range(15, 0);
      if (sel == 0) bnd = '0;
      else if (sel == 1) bnd = '1;
      else if (sel == 2) bnd = 21'd1048576;
      else if (sel < 8) bnd = 21'($urandom_range(16, 1));
      else bnd = 21'd4;
      noise = rand64();
      load_view(left, top, {noise[63], step}, {noise[63:20], cap}, {noise[63:21], bnd},
                $urandom_range(3, 0) == 0);
      n_items = $urandom_range(56, 40);
      for (int i = 0; i < n_items; i++) begin
        if (i == n_items / 2 && p % 2 == 1) drain();
        push_pixel($urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
